/* sv/plen_pkg.sv */
// Shared constants and codes for the positional list engine.
package plen_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OPCODE_W = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam int POS_MAX   = 63;
  localparam int COUNT_MAX = 127;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_RSVD   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

/* sv/plen_ram.sv */
// Entry store: one write port, one registered read port.
module plen_ram #(
  parameter int DEPTH = plen_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = plen_pkg::VALUE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/plen_seq.sv */
// Operation sequencer: walks the entry store one word at a time with a shared index unit.
module plen_seq #(
  parameter int CAPACITY = plen_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [plen_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [plen_pkg::POS_W-1:0]      in_position,
  input  logic signed [plen_pkg::VALUE_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [plen_pkg::STATUS_W-1:0]   out_status,
  output logic [plen_pkg::POS_W-1:0]      out_found_position,
  output logic [plen_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_waddr,
  output logic [plen_pkg::VALUE_W-1:0]    mem_wdata,
  output logic [AW-1:0]                   mem_raddr,
  input  logic [plen_pkg::VALUE_W-1:0]    mem_rdata
);
  import plen_pkg::*;

  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_WR, S_FIN, S_RES} state_t;

  state_t                state;
  logic [OPCODE_W-1:0]   op;
  logic [POS_W-1:0]      pos;
  logic [VALUE_W-1:0]    value;
  logic [AW-1:0]         idx;
  logic [CW-1:0]         count;
  logic [STATUS_W-1:0]   res_status;
  logic [POS_W-1:0]      res_fpos;

  logic [XW-1:0] count_x, idx_x, in_pos_x, pos_x;
  logic [AW-1:0] idx_dec, idx_inc, pos_a;
  logic          accept;

  assign count_x  = XW'(count);
  assign idx_x    = XW'(idx);
  assign in_pos_x = XW'(in_position);
  assign pos_x    = XW'(pos);
  assign idx_dec  = idx - AW'(1);
  assign idx_inc  = idx + AW'(1);
  assign pos_a    = AW'(pos);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    mem_raddr = idx;
    unique case (state)
      S_RD: begin
        if (op == OP_INSERT) begin
          mem_raddr = idx_dec;
        end else if (op == OP_DELETE) begin
          mem_raddr = idx_inc;
        end
      end
      S_WR: begin
        mem_we = (op == OP_INSERT) || (op == OP_DELETE);
      end
      S_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_a;
        mem_wdata = value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && (state != S_RES)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= in_opcode;
            pos        <= in_position;
            value      <= in_value;
            res_fpos   <= '0;
            unique case (in_opcode)
              OP_INSERT: begin
                if (count_x == XW'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  state      <= S_RES;
                end else if (in_pos_x > count_x) begin
                  res_status <= ST_RANGE;
                  state      <= S_RES;
                end else begin
                  res_status <= ST_DONE;
                  idx        <= AW'(count);
                  state      <= (in_pos_x == count_x) ? S_FIN : S_RD;
                end
              end
              OP_DELETE: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RES;
                end else if (in_pos_x >= count_x) begin
                  res_status <= ST_RANGE;
                  state      <= S_RES;
                end else if (in_pos_x + XW'(1) == count_x) begin
                  res_status <= ST_DONE;
                  count      <= count - CW'(1);
                  state      <= S_RES;
                end else begin
                  res_status <= ST_DONE;
                  idx        <= AW'(in_position);
                  state      <= S_RD;
                end
              end
              OP_SEARCH: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RES;
                end else begin
                  res_status <= ST_DONE;
                  idx        <= '0;
                  state      <= S_RD;
                end
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_RES;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          unique case (op)
            OP_INSERT: begin
              idx   <= idx_dec;
              state <= (XW'(idx_dec) == pos_x) ? S_FIN : S_RD;
            end
            OP_DELETE: begin
              if (idx_x + XW'(2) == count_x) begin
                count <= count - CW'(1);
                state <= S_RES;
              end else begin
                idx   <= idx_inc;
                state <= S_RD;
              end
            end
            default: begin
              if (mem_rdata == value) begin
                res_fpos <= POS_W'(idx);
                state    <= S_RES;
              end else if ((idx_x + XW'(1) == count_x) || (idx_x == XW'(POS_MAX))) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_RES;
              end else begin
                idx   <= idx_inc;
                state <= S_RD;
              end
            end
          endcase
        end
        S_FIN: begin
          count <= count + CW'(1);
          state <= S_RES;
        end
        S_RES: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_status         <= res_status;
            out_found_position <= res_fpos;
            out_entry_count    <= (count_x > XW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                             : count_x[COUNT_W-1:0];
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/positional_list_engine_top.sv */
// Top level of the positional list engine: stream ports, sequencer and entry store.
//
// Requests arrive on the s_ group: s_tuser carries the opcode (insert, delete,
// search), s_tdata the position and value. One result per request leaves on the
// m_ group: m_tuser carries the status, m_tdata the found position and count.
// A request is taken when s_tvalid and s_tready are both high; s_tready is high
// only while the sequencer is idle, so one request is in work at a time.
// Each shifted entry costs one store read and one store write, and
// each searched entry one read and one compare, all through the
// single read port of the entry store.
// s_tready returns in the same cycle that the result is registered.
// The result register parts the two sides: a new request is taken while a
// result waits, and a later result waits in the sequencer until m_tready.
// Synchronous reset empties the list and drops any pending result; the store
// itself is not cleared, as only entries below the count are ever read.
module positional_list_engine_top #(
  parameter int CAPACITY = plen_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero[39:38]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // found_position[5:0], entry_count[12:6], zero[15:13]
  output logic [2:0]  m_tuser    // status[2:0]
);
  import plen_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata;
  logic [POS_W-1:0]   found_position;
  logic [COUNT_W-1:0] entry_count;

  plen_seq #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_seq (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (s_tvalid),
    .in_ready           (s_tready),
    .in_opcode          (s_tuser),
    .in_position        (s_tdata[5:0]),
    .in_value           (s_tdata[37:6]),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_status         (m_tuser),
    .out_found_position (found_position),
    .out_entry_count    (entry_count),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata)
  );

  plen_ram #(.DEPTH(CAPACITY), .AW(AW), .DW(VALUE_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign m_tdata = {3'b000, entry_count, found_position};
endmodule

/* sv/plen_checker.sv */
// Port-level checks for the positional list engine, bound to the top level.
module plen_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import plen_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_DONE) || (m_tuser == ST_NOT_FOUND) ||
                 (m_tuser == ST_RANGE) || (m_tuser == ST_FULL) || (m_tuser == ST_EMPTY))
    else $error("bad status code");

  a_fpos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[5:0] != 6'd0) |-> m_tuser == ST_DONE)
    else $error("found position set on a failed request");
endmodule

bind positional_list_engine_top plen_checker u_plen_checker (.*);

/* dv/tb_positional_list_engine_top.sv */
// Testbench for the positional list engine: random and directed requests, scoreboard check.
module tb_positional_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plen_pkg::*;

  localparam int CYCLE_LIMIT = 1200000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY_DEF + 24;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_t;

  class list_scoreboard;
    typedef struct {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    found_pos;
      logic [COUNT_W-1:0]  count;
    } outcome_t;

    logic [VALUE_W-1:0] cells[$];
    outcome_t           expected_q[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] val);
      outcome_t r;
      int n;
      bit hit;
      n = cells.size();
      hit = 1'b0;
      r.status = ST_DONE;
      r.found_pos = '0;
      case (op)
        OP_INSERT: begin
          if (n >= CAPACITY_DEF) r.status = ST_FULL;
          else if (int'(pos) > n) r.status = ST_RANGE;
          else cells.insert(int'(pos), val);
        end
        OP_DELETE: begin
          if (n == 0) r.status = ST_EMPTY;
          else if (int'(pos) >= n) r.status = ST_RANGE;
          else cells.delete(int'(pos));
        end
        OP_SEARCH: begin
          if (n == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < n && !hit; i++) begin
              if (cells[i] == val) begin
                hit = 1'b1;
                // first match past the reportable range reads as a miss
                if (i <= POS_MAX) begin
                  r.status = ST_DONE;
                  r.found_pos = i[POS_W-1:0];
                end
              end
            end
          end
        end
        default: ;
      endcase
      n = cells.size();
      r.count = (n > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : n[COUNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] found_pos,
                               logic [COUNT_W-1:0] count);
      outcome_t r;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: status %0d", status);
        errors++;
      end else begin
        r = expected_q.pop_front();
        if (status !== r.status) begin
          $error("status: expected %0d, got %0d", r.status, status);
          errors++;
        end
        if (found_pos !== r.found_pos) begin
          $error("found_position: expected %0d, got %0d", r.found_pos, found_pos);
          errors++;
        end
        if (count !== r.count) begin
          $error("entry_count: expected %0d, got %0d", r.count, count);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // position[5:0], value[37:6], zero[39:38]
  logic [1:0]  s_tuser;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // found_position[5:0], entry_count[12:6], zero[15:13]
  logic [2:0]  m_tuser;   // status[2:0]

  list_scoreboard sb;
  bit             no_idle;
  int             cycles = 0;

  positional_list_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_positional_list_engine_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[5:0], s_tdata[37:6]);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[5:0], m_tdata[12:6]);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) >= 4) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      default: return 32'h5A5A_5A5A;
    endcase
  endfunction

  // entered at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, val, pos};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic directed_requests();
    send_request(OP_SEARCH, 6'd0,  32'h0000_0000);
    send_request(OP_DELETE, 6'd0,  32'h0000_0000);
    send_request(OP_DELETE, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 6'd1,  32'h0000_0001);
    send_request(OP_INSERT, 6'd63, 32'h0000_0002);
    send_request(OP_INSERT, 6'd0,  32'h8000_0000);
    send_request(OP_INSERT, 6'd1,  32'h7FFF_FFFF);
    send_request(OP_INSERT, 6'd0,  32'h0000_0000);
    send_request(OP_INSERT, 6'd1,  32'hFFFF_FFFF);
    send_request(OP_INSERT, 6'd4,  32'h5555_5555);
    send_request(OP_SEARCH, 6'd0,  32'h8000_0000);
    send_request(OP_SEARCH, 6'd63, 32'h0000_0000);
    send_request(OP_SEARCH, 6'd0,  32'h5555_5555);
    send_request(OP_SEARCH, 6'd0,  32'h0000_1234);
    send_request(OP_INSERT, 6'd5,  32'hFFFF_FFFF);
    send_request(OP_SEARCH, 6'd0,  32'hFFFF_FFFF);
    send_request(OP_DELETE, 6'd6,  32'h0000_0000);
    send_request(OP_DELETE, 6'd63, 32'h0000_0000);
    send_request(OP_DELETE, 6'd0,  32'h0000_0000);
    send_request(OP_DELETE, 6'd4,  32'h0000_0000);
    send_request(OP_DELETE, 6'd1,  32'h0000_0000);
    send_request(OP_RSVD,   6'd63, 32'hFFFF_FFFF);
    send_request(OP_RSVD,   6'd0,  32'h0000_0000);
    send_request(OP_INSERT, 6'd3,  32'hAAAA_AAAA);
  endtask

  // phases that fill, drain or churn the list, plus pure noise
  task automatic random_requests(input int total);
    int left;
    int run_len;
    int roll;
    int n;
    phase_t ph;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VALUE_W-1:0] val;
    left = total;
    while (left > 0) begin
      run_len = $urandom_range(40, 200);
      ph = phase_t'($urandom_range(0, 3));
      no_idle = ($urandom_range(0, 4) == 0);
      repeat (run_len) begin
        if (left > 0) begin
          n = sb.cells.size();
          roll = $urandom_range(0, 99);
          case (ph)
            PH_GROW:   op = (roll < 75) ? OP_INSERT : (roll < 85) ? OP_DELETE :
                            (roll < 95) ? OP_SEARCH : OP_RSVD;
            PH_SHRINK: op = (roll < 15) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                            (roll < 95) ? OP_SEARCH : OP_RSVD;
            PH_MIXED:  op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_DELETE :
                            (roll < 95) ? OP_SEARCH : OP_RSVD;
            default:   op = OPCODE_W'($urandom_range(0, 3));
          endcase
          if (ph == PH_NOISE || $urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 63));
          else pos = POS_W'($urandom_range(0, (n > POS_MAX) ? POS_MAX : n));
          if (op == OP_SEARCH && n > 0 && $urandom_range(0, 9) < 7)
            val = sb.cells[$urandom_range(0, n - 1)];
          else
            val = pick_value();
          send_request(op, pos, val);
          left--;
        end
      end
    end
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin : ready_gen
      int run_left;
      int stall_left;
      @(negedge clk);
      if (no_idle) begin
        m_tready <= 1'b1;
      end else if (run_left > 0) begin
        m_tready <= 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        run_left = $urandom_range(0, 11);
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    rst      = 1'b1;
    no_idle  = 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_requests();
    random_requests(1500);
    s_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_positional_list_engine_top: clean");
    end else begin
      $display("tb_positional_list_engine_top: errors");
    end
    $finish;
  end

endmodule
